### rtl/rycb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rycb_pkg: shared types and constants of the RGB555 to YCbCr blender
// Holds the pixel layout, the fixed-point widths and the coefficient tables of
// the three color standards in TV and full range.
// ----------------------------------------------------------------------------
package rycb_pkg;

    // Pixel word layout
    localparam int PIX_W   = 19;
    localparam int CH_W    = 5;
    localparam int LVL_W   = 4;
    localparam int R_LSB   = 0;
    localparam int G_LSB   = 5;
    localparam int B_LSB   = 10;
    localparam int L_LSB   = 15;

    // Datapath widths
    localparam int SC_W    = 9;   // scaled channel, 0..496
    localparam int COEF_W  = 31;  // coefficient magnitude, 32 fraction bits
    localparam int PROD_W  = COEF_W + SC_W;
    localparam int SUM_W   = PROD_W + 3;
    localparam int VAL_W   = 30;  // per-pixel value, 22 fraction bits
    localparam int ACC_W   = 32;
    localparam int OUT_W   = 16;
    localparam int YOFF_W  = 5;
    localparam int FRAC_IN = 32;
    localparam int FRAC_DROP = 10;
    localparam int OUT_SH16  = 14;
    localparam int OUT_SH8   = 22;
    localparam int CHROMA_OFF = 128;
    localparam int LUMA_OFF_TV = 16;

    // Channel and color indexes
    localparam int CH_Y  = 0;
    localparam int CH_CB = 1;
    localparam int CH_CR = 2;
    localparam int COL_R = 0;
    localparam int COL_G = 1;
    localparam int COL_B = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STD   = 2'd0;
    localparam logic [1:0] CFG_FULL  = 2'd1;
    localparam logic [1:0] CFG_EIGHT = 2'd2;

    // Color standard codes
    localparam logic [1:0] STD_601  = 2'd0;
    localparam logic [1:0] STD_709  = 2'd1;
    localparam logic [1:0] STD_240M = 2'd2;

    // Coefficient derivation, all resolved at elaboration
    localparam longint ONE32 = 64'sd4294967296;
    localparam longint KDEN  = 10000;
    localparam longint RDIV  = 496;
    localparam longint KR [0:2] = '{2990, 2126, 2120};
    localparam longint KB [0:2] = '{1140, 722, 870};
    localparam longint KG [0:2] = '{KDEN - KR[0] - KB[0], KDEN - KR[1] - KB[1],
                                    KDEN - KR[2] - KB[2]};
    localparam longint SY [0:1] = '{219, 255};
    localparam longint SC [0:1] = '{224, 255};
    localparam longint DY = KDEN * RDIV;
    localparam longint DH = 2 * RDIV;
    localparam longint DB [0:2] = '{2 * (KDEN - KB[0]) * RDIV, 2 * (KDEN - KB[1]) * RDIV,
                                    2 * (KDEN - KB[2]) * RDIV};
    localparam longint DR [0:2] = '{2 * (KDEN - KR[0]) * RDIV, 2 * (KDEN - KR[1]) * RDIV,
                                    2 * (KDEN - KR[2]) * RDIV};

    // Tables indexed by {standard, full_range}; magnitudes rounded to nearest
    localparam longint YR [0:5] = '{
        (2 * KR[0] * SY[0] * ONE32 + DY) / (2 * DY), (2 * KR[0] * SY[1] * ONE32 + DY) / (2 * DY),
        (2 * KR[1] * SY[0] * ONE32 + DY) / (2 * DY), (2 * KR[1] * SY[1] * ONE32 + DY) / (2 * DY),
        (2 * KR[2] * SY[0] * ONE32 + DY) / (2 * DY), (2 * KR[2] * SY[1] * ONE32 + DY) / (2 * DY)};
    localparam longint YG [0:5] = '{
        (2 * KG[0] * SY[0] * ONE32 + DY) / (2 * DY), (2 * KG[0] * SY[1] * ONE32 + DY) / (2 * DY),
        (2 * KG[1] * SY[0] * ONE32 + DY) / (2 * DY), (2 * KG[1] * SY[1] * ONE32 + DY) / (2 * DY),
        (2 * KG[2] * SY[0] * ONE32 + DY) / (2 * DY), (2 * KG[2] * SY[1] * ONE32 + DY) / (2 * DY)};
    localparam longint YB [0:5] = '{
        (2 * KB[0] * SY[0] * ONE32 + DY) / (2 * DY), (2 * KB[0] * SY[1] * ONE32 + DY) / (2 * DY),
        (2 * KB[1] * SY[0] * ONE32 + DY) / (2 * DY), (2 * KB[1] * SY[1] * ONE32 + DY) / (2 * DY),
        (2 * KB[2] * SY[0] * ONE32 + DY) / (2 * DY), (2 * KB[2] * SY[1] * ONE32 + DY) / (2 * DY)};
    localparam longint CBR [0:5] = '{
        (2 * KR[0] * SC[0] * ONE32 + DB[0]) / (2 * DB[0]),
        (2 * KR[0] * SC[1] * ONE32 + DB[0]) / (2 * DB[0]),
        (2 * KR[1] * SC[0] * ONE32 + DB[1]) / (2 * DB[1]),
        (2 * KR[1] * SC[1] * ONE32 + DB[1]) / (2 * DB[1]),
        (2 * KR[2] * SC[0] * ONE32 + DB[2]) / (2 * DB[2]),
        (2 * KR[2] * SC[1] * ONE32 + DB[2]) / (2 * DB[2])};
    localparam longint CBG [0:5] = '{
        (2 * KG[0] * SC[0] * ONE32 + DB[0]) / (2 * DB[0]),
        (2 * KG[0] * SC[1] * ONE32 + DB[0]) / (2 * DB[0]),
        (2 * KG[1] * SC[0] * ONE32 + DB[1]) / (2 * DB[1]),
        (2 * KG[1] * SC[1] * ONE32 + DB[1]) / (2 * DB[1]),
        (2 * KG[2] * SC[0] * ONE32 + DB[2]) / (2 * DB[2]),
        (2 * KG[2] * SC[1] * ONE32 + DB[2]) / (2 * DB[2])};
    localparam longint CRG [0:5] = '{
        (2 * KG[0] * SC[0] * ONE32 + DR[0]) / (2 * DR[0]),
        (2 * KG[0] * SC[1] * ONE32 + DR[0]) / (2 * DR[0]),
        (2 * KG[1] * SC[0] * ONE32 + DR[1]) / (2 * DR[1]),
        (2 * KG[1] * SC[1] * ONE32 + DR[1]) / (2 * DR[1]),
        (2 * KG[2] * SC[0] * ONE32 + DR[2]) / (2 * DR[2]),
        (2 * KG[2] * SC[1] * ONE32 + DR[2]) / (2 * DR[2])};
    localparam longint CRB [0:5] = '{
        (2 * KB[0] * SC[0] * ONE32 + DR[0]) / (2 * DR[0]),
        (2 * KB[0] * SC[1] * ONE32 + DR[0]) / (2 * DR[0]),
        (2 * KB[1] * SC[0] * ONE32 + DR[1]) / (2 * DR[1]),
        (2 * KB[1] * SC[1] * ONE32 + DR[1]) / (2 * DR[1]),
        (2 * KB[2] * SC[0] * ONE32 + DR[2]) / (2 * DR[2]),
        (2 * KB[2] * SC[1] * ONE32 + DR[2]) / (2 * DR[2])};
    // Unit chroma weight, depends on the range only
    localparam longint HALF [0:1] = '{
        (2 * SC[0] * ONE32 + DH) / (2 * DH), (2 * SC[1] * ONE32 + DH) / (2 * DH)};

    // Selected coefficient set: magnitudes [channel][color], signs are fixed
    typedef struct packed {
        logic [2:0][2:0][COEF_W-1:0] mag;
        logic [YOFF_W-1:0]           y_off;
    } t_coef;

    // Per-pixel Y, Cb, Cr values
    typedef logic [2:0][VAL_W-1:0] t_ycc;

    // Control that travels with each beat
    typedef struct packed {
        logic       vld;
        logic [1:0] cnt;
    } t_ctl;

    // Pick the coefficient set; unknown standard falls back to BT.601
    function automatic t_coef coef_select(input logic [1:0] std, input logic full);
        t_coef      c;
        logic [1:0] k;
        logic [2:0] idx;
        case (std)
            STD_709:  k = 2'd1;
            STD_240M: k = 2'd2;
            default:  k = 2'd0;
        endcase
        idx = {k, full};
        c.mag[CH_Y][COL_R]  = COEF_W'(YR[idx]);
        c.mag[CH_Y][COL_G]  = COEF_W'(YG[idx]);
        c.mag[CH_Y][COL_B]  = COEF_W'(YB[idx]);
        c.mag[CH_CB][COL_R] = COEF_W'(CBR[idx]);
        c.mag[CH_CB][COL_G] = COEF_W'(CBG[idx]);
        c.mag[CH_CB][COL_B] = COEF_W'(HALF[full]);
        c.mag[CH_CR][COL_R] = COEF_W'(HALF[full]);
        c.mag[CH_CR][COL_G] = COEF_W'(CRG[idx]);
        c.mag[CH_CR][COL_B] = COEF_W'(CRB[idx]);
        c.y_off = full ? YOFF_W'(0) : YOFF_W'(LUMA_OFF_TV);
        return c;
    endfunction

endpackage

### rtl/rycb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rycb_lane: one pixel lane of the converter
// Three register stages: level scaling, coefficient products, signed sum with
// offset, rounding to 22 fraction bits and clamping to 30 bits.
// ----------------------------------------------------------------------------
module rycb_lane import rycb_pkg::*; (
    input  logic             i_clk,
    input  logic [PIX_W-1:0] i_pixel,
    input  t_coef            i_coef,
    output t_ycc             o_val
);

    logic [2:0][SC_W-1:0]           r_rgb;
    logic [2:0][SC_W-1:0]           n_rgb;
    logic [2:0][2:0][PROD_W-1:0]    r_prod;
    logic [2:0][2:0][PROD_W-1:0]    n_prod;
    t_ycc                           r_val;
    t_ycc                           n_val;
    logic [CH_W:0]                  lvl;
    logic signed [2:0][2:0][SUM_W-1:0] term;
    logic signed [SUM_W-1:0]        off_y;
    logic signed [SUM_W-1:0]        off_c;
    logic signed [SUM_W-1:0]        s_y;
    logic signed [SUM_W-1:0]        s_cb;
    logic signed [SUM_W-1:0]        s_cr;

    // Round off the low fraction bits, clamp to the 30-bit range
    function automatic logic [VAL_W-1:0] fix_round(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] w;
        w = (SUM_W'(s) + SUM_W'(1 << (FRAC_DROP - 1))) >> FRAC_DROP;
        if (s < 0) begin
            return '0;
        end else if (|w[SUM_W-1:VAL_W]) begin
            return '1;
        end
        return w[VAL_W-1:0];
    endfunction

    // Scale each channel by level + 1
    always_comb begin
        lvl      = {2'b00, i_pixel[L_LSB +: LVL_W]} + (CH_W+1)'(1);
        n_rgb[COL_R] = SC_W'(lvl) * SC_W'(i_pixel[R_LSB +: CH_W]);
        n_rgb[COL_G] = SC_W'(lvl) * SC_W'(i_pixel[G_LSB +: CH_W]);
        n_rgb[COL_B] = SC_W'(lvl) * SC_W'(i_pixel[B_LSB +: CH_W]);
    end

    // Form the nine coefficient products
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[c][k] = PROD_W'(i_coef.mag[c][k]) * PROD_W'(r_rgb[k]);
            end
        end
    end

    // Combine products with their signs and the channel offsets
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                term[c][k] = $signed(SUM_W'(r_prod[c][k]));
            end
        end
        off_y = $signed(SUM_W'(i_coef.y_off) << FRAC_IN);
        off_c = $signed(SUM_W'(CHROMA_OFF) << FRAC_IN);
        s_y   = term[CH_Y][COL_R] + term[CH_Y][COL_G] + term[CH_Y][COL_B] + off_y;
        s_cb  = term[CH_CB][COL_B] - term[CH_CB][COL_R] - term[CH_CB][COL_G] + off_c;
        s_cr  = term[CH_CR][COL_R] - term[CH_CR][COL_G] - term[CH_CR][COL_B] + off_c;
        n_val[CH_Y]  = fix_round(s_y);
        n_val[CH_CB] = fix_round(s_cb);
        n_val[CH_CR] = fix_round(s_cr);
    end

    // Advance the lane every cycle; valid bits travel in the top level
    always_ff @(posedge i_clk) begin
        r_rgb  <= n_rgb;
        r_prod <= n_prod;
        r_val  <= n_val;
    end

    assign o_val = r_val;

endmodule

### rtl/rycb_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rycb_blend: pixel averaging and output formatting
// Sums the selected lanes, divides by the pixel count and cuts the result to
// the 16-bit or 8-bit output format in one register stage.
// ----------------------------------------------------------------------------
module rycb_blend import rycb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  logic             i_eight,
    input  t_ycc [3:0]       i_val,
    output logic             o_strobe,
    output logic [OUT_W-1:0] o_luma,
    output logic [OUT_W-1:0] o_cb,
    output logic [OUT_W-1:0] o_cr
);

    logic                   r_strobe;
    logic [2:0][OUT_W-1:0]  r_out;
    logic [2:0][OUT_W-1:0]  n_out;
    logic                   use_b;
    logic                   use_cd;
    logic [1:0]             sh;
    logic [2:0][ACC_W-1:0]  acc;
    logic [2:0][ACC_W-1:0]  avg;

    // Sum the used pixels, shift by log2 of the count, pick the format
    always_comb begin
        use_b  = i_ctl.cnt[1] | i_ctl.cnt[0];
        use_cd = i_ctl.cnt[1];
        sh     = i_ctl.cnt[1] ? 2'd2 : {1'b0, i_ctl.cnt[0]};
        for (int c = 0; c < 3; c++) begin
            acc[c] = ACC_W'(i_val[0][c])
                   + (use_b  ? ACC_W'(i_val[1][c]) : '0)
                   + (use_cd ? ACC_W'(i_val[2][c]) + ACC_W'(i_val[3][c]) : '0);
            avg[c] = acc[c] >> sh;
            n_out[c] = i_eight ? OUT_W'(avg[c] >> OUT_SH8) : OUT_W'(avg[c] >> OUT_SH16);
        end
    end

    // Strobe control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.vld;
        end
    end

    // Hold the result until the next beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_strobe;
    assign o_luma   = r_out[CH_Y];
    assign o_cb     = r_out[CH_CB];
    assign o_cr     = r_out[CH_CR];

endmodule

### rtl/rgb555_to_ycbcr_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb555_to_ycbcr_blend: RGB555 with level to YCbCr converter and blender
// An accepted beat passes r_ctl[0], r_ctl[1], r_ctl[2], then r_strobe.
// Throughput: one beat per cycle; busy stays low, the four-stage lane pipeline
// (scale, multiply, sum, blend) takes a new pixel group every clock.
// Reset: synchronous, active low; clears the valid bits and the config registers
// (BT.601, TV range, 16-bit output). The receiver cannot stall.
// ----------------------------------------------------------------------------
module rgb555_to_ycbcr_blend import rycb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [1:0]       i_cfg_data,
    input  logic [PIX_W-1:0] i_pixel_a,
    input  logic [PIX_W-1:0] i_pixel_b,
    input  logic [PIX_W-1:0] i_pixel_c,
    input  logic [PIX_W-1:0] i_pixel_d,
    input  logic [1:0]       i_blend_count,
    output logic             o_strobe,
    output logic [OUT_W-1:0] o_luma,
    output logic [OUT_W-1:0] o_chroma_blue,
    output logic [OUT_W-1:0] o_chroma_red
);

    logic [1:0]             r_std;
    logic                   r_full;
    logic                   r_eight;
    t_coef                  r_coef;
    t_ctl [2:0]             r_ctl;
    logic [3:0][PIX_W-1:0]  pix;
    t_ycc [3:0]             val;

    assign busy = 1'b0;
    assign pix  = {i_pixel_d, i_pixel_c, i_pixel_b, i_pixel_a};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std   <= STD_601;
            r_full  <= 1'b0;
            r_eight <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STD:   r_std   <= i_cfg_data;
                CFG_FULL:  r_full  <= i_cfg_data[0];
                CFG_EIGHT: r_eight <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Refresh the coefficient set from the registers
    always_ff @(posedge i_clk) begin
        r_coef <= coef_select(r_std, r_full);
    end

    // Advance valid and count alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl[0] <= '{vld: start & ~busy, cnt: i_blend_count};
            r_ctl[1] <= r_ctl[0];
            r_ctl[2] <= r_ctl[1];
        end
    end

    // One lane per pixel
    for (genvar p = 0; p < 4; p++) begin : g_lane
        rycb_lane u_lane (
            .i_clk   (i_clk),
            .i_pixel (pix[p]),
            .i_coef  (r_coef),
            .o_val   (val[p])
        );
    end

    rycb_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_ctl[2]),
        .i_eight  (r_eight),
        .i_val    (val),
        .o_strobe (o_strobe),
        .o_luma   (o_luma),
        .o_cb     (o_chroma_blue),
        .o_cr     (o_chroma_red)
    );

`ifndef SYNTH
    // Every accepted beat yields a strobe after the pipeline depth
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted beat produced no result");

    // No strobe without a beat accepted at the pipeline depth before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 4))
        else $error("result strobe without an accepted beat");

    // Eight-bit format leaves the upper bits clear
    a_eight_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(r_eight)) |->
            (o_luma[15:10] == 6'd0 && o_chroma_blue[15:10] == 6'd0 &&
             o_chroma_red[15:10] == 6'd0))
        else $error("eight-bit result wider than expected");
`endif

endmodule
